// File: sv/led_seq_pkg.sv
package led_seq_pkg;

    // register widths
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 5;

    // register indexes
    localparam logic [CfgIndexWidth-1:0] REG_STEP_TICKS    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_BLINK_TICKS   = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_SWEEP_REPEATS = 2'd2;
    localparam logic [CfgIndexWidth-1:0] REG_BLINK_TOGGLES = 2'd3;

    // register reset values
    localparam logic [3:0] STEP_TICKS_RESET    = 4'd2;
    localparam logic [3:0] BLINK_TICKS_RESET   = 4'd5;
    localparam logic [3:0] SWEEP_REPEATS_RESET = 4'd4;
    localparam logic [4:0] BLINK_TOGGLES_RESET = 5'd9;

    // fill phase starting and last pairs
    localparam logic [3:0] UPPER_START = 4'd4;
    localparam logic [2:0] LOWER_START = 3'd3;
    localparam logic [3:0] UPPER_LAST  = 4'd7;
    localparam logic [2:0] LOWER_LAST  = 3'd0;

    typedef enum logic [5:0] {
        PH_LEFT  = 6'b000001,
        PH_RIGHT = 6'b000010,
        PH_IN    = 6'b000100,
        PH_OUT   = 6'b001000,
        PH_BLINK = 6'b010000,
        PH_HALT  = 6'b100000
    } phase_t;

    // set or clear one led, positions past the last led do nothing
    function automatic logic [7:0] pin_write(input logic [7:0] leds,
                                             input logic [4:0] pos,
                                             input logic       on);
        logic [7:0] mask;
        mask = 8'd0;
        if (pos < 5'd8)
        begin
            mask[pos[2:0]] = 1'b1;
        end
        if (on)
        begin
            pin_write = leds | mask;
        end
        else
        begin
            pin_write = leds & ~mask;
        end
    endfunction

endpackage

// File: sv/led_pattern_sequencer.sv
// led pattern sequencer: eight leds run a fixed animation that moves on only when an
// input transfer carries tick = 1; every input transfer yields exactly one result
// transfer with the led levels after that item and a halted flag. the animation is a
// one-light chaser that sweeps up and back sweep_repeats times, then a center-out fill
// and edge-in clear repeated sweep_repeats times, then all leds toggling every
// blink_ticks ticks until blink_toggles toggles have been done, after which ticks are
// ignored. the chaser and fill advance once every step_ticks ticks.
// the sequencer state and the result register are updated at the accepting
// edge, and a new item is taken in every cycle as long as the result register is empty
// or being drained in that same cycle. configuration is written through cfg_we,
// cfg_index and cfg_data, and is meant to change only while no item is in flight.
module led_pattern_sequencer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [led_seq_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [led_seq_pkg::CfgDataWidth-1:0]   cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   tick,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [7:0]                             led_pattern,
    output logic                                   halted
);

    import led_seq_pkg::*;

    // configuration registers
    logic [3:0] step_ticks_reg;
    logic [3:0] blink_ticks_reg;
    logic [3:0] sweep_repeats_reg;
    logic [4:0] blink_toggles_reg;

    // sequencer state
    phase_t     phase_reg, phase_next;
    logic [3:0] tick_count_reg, tick_count_next;
    logic [3:0] chase_position_reg, chase_position_next;
    logic [4:0] repeat_count_reg, repeat_count_next;
    logic [3:0] upper_index_reg, upper_index_next;
    logic [2:0] lower_index_reg, lower_index_next;
    logic [7:0] leds_reg, leds_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] led_pattern_reg;
    logic       halted_reg;

    logic in_accept;
    logic out_accept;

    // the result register frees up in the same cycle it is drained
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // configuration writes, unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ticks_reg    <= STEP_TICKS_RESET;
            blink_ticks_reg   <= BLINK_TICKS_RESET;
            sweep_repeats_reg <= SWEEP_REPEATS_RESET;
            blink_toggles_reg <= BLINK_TOGGLES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_TICKS:    step_ticks_reg    <= cfg_data[3:0];
                REG_BLINK_TICKS:   blink_ticks_reg   <= cfg_data[3:0];
                REG_SWEEP_REPEATS: sweep_repeats_reg <= cfg_data[3:0];
                REG_BLINK_TOGGLES: blink_toggles_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // next state for one item
    always_comb
    begin
        logic [3:0] limit;
        logic [3:0] tc;
        logic [3:0] pos;

        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        chase_position_next = chase_position_reg;
        repeat_count_next   = repeat_count_reg;
        upper_index_next    = upper_index_reg;
        lower_index_next    = lower_index_reg;
        leds_next           = leds_reg;
        limit               = (phase_reg == PH_BLINK) ? blink_ticks_reg : step_ticks_reg;
        tc                  = tick_count_reg + 4'd1;
        pos                 = chase_position_reg;

        if (tick && phase_reg != PH_HALT)
        begin
            tick_count_next = tc;
            if (tc == limit)
            begin
                tick_count_next = 4'd0;
                unique case (phase_reg)
                    PH_LEFT:
                    begin
                        // light the current led, darken the one behind it
                        leds_next = pin_write(leds_next, {1'b0, pos}, 1'b1);
                        if (pos != 4'd0)
                        begin
                            leds_next = pin_write(leds_next, {1'b0, pos - 4'd1}, 1'b0);
                        end
                        chase_position_next = pos + 4'd1;
                        if (chase_position_next > 4'd7)
                        begin
                            phase_next = PH_RIGHT;
                        end
                    end
                    PH_RIGHT:
                    begin
                        pos                 = chase_position_reg - 4'd1;
                        chase_position_next = pos;
                        leds_next = pin_write(leds_next, {1'b0, pos}, 1'b1);
                        leds_next = pin_write(leds_next, {1'b0, pos} + 5'd1, 1'b0);
                        if (pos == 4'd0)
                        begin
                            phase_next        = PH_LEFT;
                            repeat_count_next = repeat_count_reg + 5'd1;
                        end
                        // round trips done, move on to the fill
                        if (repeat_count_next == {1'b0, sweep_repeats_reg})
                        begin
                            phase_next        = PH_IN;
                            repeat_count_next = 5'd0;
                        end
                    end
                    PH_IN:
                    begin
                        leds_next = pin_write(leds_next, {1'b0, upper_index_reg}, 1'b1);
                        leds_next = pin_write(leds_next, {2'b00, lower_index_reg}, 1'b1);
                        upper_index_next = upper_index_reg + 4'd1;
                        lower_index_next = lower_index_reg - 3'd1;
                        if (upper_index_next > UPPER_LAST)
                        begin
                            upper_index_next = UPPER_LAST;
                            lower_index_next = LOWER_LAST;
                            phase_next       = PH_OUT;
                        end
                    end
                    PH_OUT:
                    begin
                        leds_next = pin_write(leds_next, {1'b0, upper_index_reg}, 1'b0);
                        leds_next = pin_write(leds_next, {2'b00, lower_index_reg}, 1'b0);
                        upper_index_next = upper_index_reg - 4'd1;
                        lower_index_next = lower_index_reg + 3'd1;
                        if (upper_index_next < UPPER_START)
                        begin
                            upper_index_next  = UPPER_START;
                            lower_index_next  = LOWER_START;
                            phase_next        = PH_IN;
                            repeat_count_next = repeat_count_reg + 5'd1;
                        end
                        if (repeat_count_next == {1'b0, sweep_repeats_reg})
                        begin
                            phase_next        = PH_BLINK;
                            repeat_count_next = 5'd0;
                        end
                    end
                    PH_BLINK:
                    begin
                        leds_next         = ~leds_reg;
                        repeat_count_next = repeat_count_reg + 5'd1;
                        if (repeat_count_next >= blink_toggles_reg)
                        begin
                            phase_next = PH_HALT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // state and result update on each accepted item, valid cleared when the result is drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_LEFT;
            tick_count_reg     <= 4'd0;
            chase_position_reg <= 4'd0;
            repeat_count_reg   <= 5'd0;
            upper_index_reg    <= UPPER_START;
            lower_index_reg    <= LOWER_START;
            leds_reg           <= 8'd0;
            out_valid_reg      <= 1'b0;
            halted_reg         <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg          <= phase_next;
                tick_count_reg     <= tick_count_next;
                chase_position_reg <= chase_position_next;
                repeat_count_reg   <= repeat_count_next;
                upper_index_reg    <= upper_index_next;
                lower_index_reg    <= lower_index_next;
                leds_reg           <= leds_next;
                halted_reg         <= (phase_next == PH_HALT);
                out_valid_reg      <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // led payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            led_pattern_reg <= leds_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_pattern = led_pattern_reg;
    assign halted      = halted_reg;

    // once halted the sequencer never moves again
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT && $stable(leds_reg))
        else $error("sequencer left the halted state");

    // halted flag tracks the phase register
    a_halted_match: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg == (phase_reg == PH_HALT))
        else $error("halted flag out of step with phase");

    // every accepted item leaves a result waiting
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // upper fill index stays inside the upper half
    a_upper_range: assert property (@(posedge clk) disable iff (!rst_n)
        upper_index_reg >= UPPER_START && upper_index_reg <= UPPER_LAST)
        else $error("upper fill index out of range");

    // chaser never runs past one beyond the last led
    a_chase_range: assert property (@(posedge clk) disable iff (!rst_n)
        chase_position_reg <= 4'd8)
        else $error("chase position out of range");

endmodule
